@@ design/rpdb_pkg.sv @@
// shared types, register codes and color expansion for the pixmap decode and blend unit
package rpdb_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_FORMAT      = 3'd0;
   localparam logic [2:0] CSR_ALPHA       = 3'd1;
   localparam logic [2:0] CSR_WIDTH       = 3'd2;
   localparam logic [2:0] CSR_HEIGHT      = 3'd3;
   localparam logic [2:0] CSR_CLIP_X_LOW  = 3'd4;
   localparam logic [2:0] CSR_CLIP_X_HIGH = 3'd5;
   localparam logic [2:0] CSR_CLIP_Y_LOW  = 3'd6;
   localparam logic [2:0] CSR_CLIP_Y_HIGH = 3'd7;

   localparam int CSR_DATA_W = 12;

   // pixel format codes, codes six and seven decode as raw888
   localparam logic [2:0] FMT_RAW332 = 3'd0;
   localparam logic [2:0] FMT_RAW565 = 3'd1;
   localparam logic [2:0] FMT_RAW888 = 3'd2;
   localparam logic [2:0] FMT_RLE332 = 3'd3;
   localparam logic [2:0] FMT_RLE565 = 3'd4;
   localparam logic [2:0] FMT_RLE888 = 3'd5;

   // source color layouts
   localparam logic [1:0] KIND_332 = 2'd0;
   localparam logic [1:0] KIND_565 = 2'd1;
   localparam logic [1:0] KIND_888 = 2'd2;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0]  record_count;
      logic [23:0] record_color;
      logic [23:0] background_color;
   } req_beat_type;

   typedef struct packed {
      logic [23:0] pixel_color;
      logic        pixel_visible;
      logic        record_taken;
      logic        image_done;
   } rsp_beat_type;

   typedef struct packed {
      logic [2:0]  pixel_format;
      logic [7:0]  alpha;
      logic [11:0] image_width;
      logic [11:0] image_height;
      logic [10:0] clip_x_low;
      logic [10:0] clip_x_high;
      logic [10:0] clip_y_low;
      logic [10:0] clip_y_high;
   } cfg_type;

   // one classified pixel handed from front to back
   typedef struct packed {
      logic [23:0] fg;
      logic [23:0] bg;
      logic        visible;
      logic        taken;
      logic        done;
   } job_type;

   function automatic logic [7:0] rep3(input logic [2:0] v);
      return {v, v, v[2:1]};
   endfunction

   function automatic logic [7:0] rep5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   function automatic logic [7:0] rep6(input logic [5:0] v);
      return {v, v[5:4]};
   endfunction

   // expand a raw source color to rgb888 by bit replication
   function automatic logic [23:0] expand_color(input logic [1:0] kind, input logic [23:0] raw);
      logic [23:0] res;
      case (kind)
         KIND_332: res = {rep3(raw[7:5]), rep3(raw[4:2]), {4{raw[1:0]}}};
         KIND_565: res = {rep5(raw[15:11]), rep6(raw[10:5]), rep5(raw[4:0])};
         default:  res = raw;
      endcase
      return res;
   endfunction

endpackage

@@ design/rpdb_front.sv @@
// front part: run-length decode, raster position tracking and clip classification
module rpdb_front #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rpdb_pkg::cfg_type     cfg,
   input  logic                  req_valid,
   input  rpdb_pkg::req_beat_type req_beat,
   input  logic                  queue_full,
   output logic                  push,
   output rpdb_pkg::job_type     job
);
   import rpdb_pkg::*;

   localparam int XW  = $clog2(MAX_WIDTH);
   localparam int YW  = $clog2(MAX_HEIGHT);
   localparam int XCW = (XW + 1 > 13) ? XW + 1 : 13;
   localparam int YCW = (YW + 1 > 13) ? YW + 1 : 13;

   logic [8:0]    run_left_ff, run_left_in;
   logic [23:0]   run_color_ff, run_color_in;
   logic [XW-1:0] col_ff, col_in;
   logic [YW-1:0] line_ff, line_in;

   logic [1:0]     kind;
   logic           is_rle;
   logic [23:0]    expanded;
   logic [8:0]     run_load;
   logic [XCW-1:0] w_ext, w_lim, col_ext;
   logic [YCW-1:0] h_ext, h_lim, line_ext;
   logic           eol;

   assign push = req_valid && !queue_full;

   // format decode and color expansion
   always_comb begin
      case (cfg.pixel_format)
         FMT_RAW332, FMT_RLE332: kind = KIND_332;
         FMT_RAW565, FMT_RLE565: kind = KIND_565;
         default:                kind = KIND_888;
      endcase
      is_rle = (cfg.pixel_format == FMT_RLE332) || (cfg.pixel_format == FMT_RLE565) ||
               (cfg.pixel_format == FMT_RLE888);
      expanded = expand_color(kind, req_beat.record_color);
   end

   // image size limited to one through the maximum
   always_comb begin
      w_ext = XCW'(cfg.image_width);
      h_ext = YCW'(cfg.image_height);
      if (w_ext == '0) begin
         w_lim = XCW'(1);
      end else if (w_ext > XCW'(MAX_WIDTH)) begin
         w_lim = XCW'(MAX_WIDTH);
      end else begin
         w_lim = w_ext;
      end
      if (h_ext == '0) begin
         h_lim = YCW'(1);
      end else if (h_ext > YCW'(MAX_HEIGHT)) begin
         h_lim = YCW'(MAX_HEIGHT);
      end else begin
         h_lim = h_ext;
      end
      col_ext  = XCW'(col_ff);
      line_ext = YCW'(line_ff);
   end

   // classify the pixel and work out the next decoder state
   always_comb begin
      run_left_in  = run_left_ff;
      run_color_in = run_color_ff;
      col_in       = col_ff;
      line_in      = line_ff;
      run_load     = run_left_ff;

      job.bg = req_beat.background_color;
      if (is_rle) begin
         job.taken = (run_left_ff == '0);
         if (job.taken) begin
            run_load     = (req_beat.record_count == '0) ? 9'd256 : {1'b0, req_beat.record_count};
            run_color_in = expanded;
         end
         job.fg      = job.taken ? expanded : run_color_ff;
         run_left_in = run_load - 9'd1;
      end else begin
         job.taken = 1'b1;
         job.fg    = expanded;
      end

      job.visible = (col_ext >= XCW'(cfg.clip_x_low)) && (col_ext <= XCW'(cfg.clip_x_high)) &&
                    (line_ext >= YCW'(cfg.clip_y_low)) && (line_ext <= YCW'(cfg.clip_y_high));
      eol      = (col_ext + XCW'(1)) >= w_lim;
      job.done = eol && ((line_ext + YCW'(1)) >= h_lim);

      if (job.done) begin
         col_in      = '0;
         line_in     = '0;
         run_left_in = '0;
      end else if (eol) begin
         col_in  = '0;
         line_in = line_ff + YW'(1);
      end else begin
         col_in = col_ff + XW'(1);
      end
   end

   // decoder state advances on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         run_left_ff  <= '0;
         run_color_ff <= '0;
         col_ff       <= '0;
         line_ff      <= '0;
      end else if (push) begin
         run_left_ff  <= run_left_in;
         run_color_ff <= run_color_in;
         col_ff       <= col_in;
         line_ff      <= line_in;
      end
   end

   // end of image starts the next image at the origin with a fresh record
   a_done_restart: assert property (@(posedge clock) disable iff (reset)
      push && job.done |=> col_ff == '0 && line_ff == '0 && run_left_ff == '0)
      else $error("decoder state not cleared after last pixel");

   // raw formats consume every record
   a_raw_taken: assert property (@(posedge clock) disable iff (reset)
      push && !is_rle |-> job.taken)
      else $error("raw format beat did not take its record");

endmodule

@@ design/rpdb_queue.sv @@
// short register queue between the front and back parts
module rpdb_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rpdb_pkg::job_type  push_job,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output rpdb_pkg::job_type  head_job
);
   import rpdb_pkg::*;

   job_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   // pointers and fill
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue read while empty");

endmodule

@@ design/rpdb_back.sv @@
// back part: alpha blend pipeline and result register
module rpdb_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              alpha,
   input  logic                    head_valid,
   input  rpdb_pkg::job_type       head_job,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rpdb_pkg::rsp_beat_type  rsp_beat
);
   import rpdb_pkg::*;

   logic              s1_v_ff, s1_v_in;
   job_type           s1_job_ff;
   logic              s1_opaque_ff;
   logic [2:0][15:0]  s1_fa_ff, s1_fa_in;
   logic [2:0][15:0]  s1_bb_ff, s1_bb_in;
   logic              out_v_ff, out_v_in;
   rsp_beat_type      out_ff, out_in;
   logic              out_adv, s1_adv;
   logic [7:0]        inv_alpha;
   logic [15:0]       sum;
   logic [23:0]       blended;

   assign out_adv   = !out_v_ff || !rsp_stall;
   assign s1_adv    = !s1_v_ff || out_adv;
   assign pop       = head_valid && s1_adv;
   assign s1_v_in   = s1_adv ? head_valid : s1_v_ff;
   assign out_v_in  = out_adv ? s1_v_ff : out_v_ff;
   assign inv_alpha = 8'd255 - alpha;
   assign rsp_valid = out_v_ff;
   assign rsp_beat  = out_ff;

   // per channel weighted products
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         s1_fa_in[c] = 16'(head_job.fg[c*8 +: 8]) * 16'(alpha);
         s1_bb_in[c] = 16'(head_job.bg[c*8 +: 8]) * 16'(inv_alpha);
      end
   end

   // sum, scale and clip select
   always_comb begin
      blended = '0;
      sum     = '0;
      for (int c = 0; c < 3; c++) begin
         sum = s1_fa_ff[c] + s1_bb_ff[c];
         blended[c*8 +: 8] = sum[15:8];
      end
      if (s1_opaque_ff) begin
         blended = s1_job_ff.fg;
      end
      out_in.pixel_color   = s1_job_ff.visible ? blended : s1_job_ff.bg;
      out_in.pixel_visible = s1_job_ff.visible;
      out_in.record_taken  = s1_job_ff.taken;
      out_in.image_done    = s1_job_ff.done;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         out_v_ff <= out_v_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (pop) begin
         s1_job_ff    <= head_job;
         s1_opaque_ff <= (alpha == 8'd255);
         s1_fa_ff     <= s1_fa_in;
         s1_bb_ff     <= s1_bb_in;
      end
      if (out_adv && s1_v_ff) begin
         out_ff <= out_in;
      end
   end

   a_pop_fills_stage: assert property (@(posedge clock) disable iff (reset)
      pop |=> s1_v_ff)
      else $error("popped beat lost before blend stage");

endmodule

@@ design/rle_pixmap_decode_blend_unit.sv @@
// top level of the run-length pixmap decoder with alpha blend
//
//   port group | direction | beat contents
//   req_*      | in        | record count, record color, background pixel
//   rsp_*      | out       | blended pixel, visible, record taken, image done
//   csr_*      | in        | register index and write data, no read-back
//
// one pixel per clock sustained when nothing stalls; an accepted beat passes the queue,
// the blend stage and the result register before it shows on rsp_valid.
// the run and position state in the front part updates in the accepting cycle.
// a four entry queue separates the front from the two stage blend pipeline.
// reset is synchronous, clears valid bits, queue pointers and decoder state, and loads configuration defaults.
// req_stall rises only when the queue is full.
module rle_pixmap_decode_blend_unit #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rpdb_pkg::req_beat_type              req_beat,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rpdb_pkg::rsp_beat_type              rsp_beat,
   input  logic                                csr_write,
   input  logic [2:0]                          csr_index,
   input  logic [rpdb_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rpdb_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    push, full, pop, head_valid;
   job_type push_job, head_job;

   assign req_stall = full;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_FORMAT:      cfg_in.pixel_format = csr_wdata[2:0];
            CSR_ALPHA:       cfg_in.alpha        = csr_wdata[7:0];
            CSR_WIDTH:       cfg_in.image_width  = csr_wdata[11:0];
            CSR_HEIGHT:      cfg_in.image_height = csr_wdata[11:0];
            CSR_CLIP_X_LOW:  cfg_in.clip_x_low   = csr_wdata[10:0];
            CSR_CLIP_X_HIGH: cfg_in.clip_x_high  = csr_wdata[10:0];
            CSR_CLIP_Y_LOW:  cfg_in.clip_y_low   = csr_wdata[10:0];
            CSR_CLIP_Y_HIGH: cfg_in.clip_y_high  = csr_wdata[10:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_format <= FMT_RLE332;
         cfg_ff.alpha        <= 8'd255;
         cfg_ff.image_width  <= 12'd1;
         cfg_ff.image_height <= 12'd1;
         cfg_ff.clip_x_low   <= 11'd0;
         cfg_ff.clip_x_high  <= 11'd2047;
         cfg_ff.clip_y_low   <= 11'd0;
         cfg_ff.clip_y_high  <= 11'd2047;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rpdb_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_beat   (req_beat),
      .queue_full (full),
      .push       (push),
      .job        (push_job)
   );

   rpdb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   rpdb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .alpha      (cfg_ff.alpha),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_beat   (rsp_beat)
   );

endmodule

@@ tb/pixmap_check_pkg.sv @@
`timescale 1ns / 1ps
// scoreboard class that predicts and checks the blended pixel stream
package pixmap_check_pkg;
   import rpdb_pkg::*;

   localparam int IMAGE_MAX_W = 2048;
   localparam int IMAGE_MAX_H = 2048;
   localparam int REPORT_CAP  = 200;

   class pixel_scoreboard;
      cfg_type      regs;
      bit [8:0]     run_left;
      bit [23:0]    run_color;
      bit [10:0]    column;
      bit [10:0]    line;
      rsp_beat_type expected_pixels[$];
      int           error_count;
      int           reports;

      // register and decoder state as they come out of reset
      function new();
         regs.pixel_format = FMT_RLE332;
         regs.alpha        = 8'd255;
         regs.image_width  = 12'd1;
         regs.image_height = 12'd1;
         regs.clip_x_low   = 11'd0;
         regs.clip_x_high  = 11'd2047;
         regs.clip_y_low   = 11'd0;
         regs.clip_y_high  = 11'd2047;
         run_left          = '0;
         run_color         = '0;
         column            = '0;
         line              = '0;
         error_count       = 0;
         reports           = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_FORMAT:      regs.pixel_format = data[2:0];
            CSR_ALPHA:       regs.alpha        = data[7:0];
            CSR_WIDTH:       regs.image_width  = data[11:0];
            CSR_HEIGHT:      regs.image_height = data[11:0];
            CSR_CLIP_X_LOW:  regs.clip_x_low   = data[10:0];
            CSR_CLIP_X_HIGH: regs.clip_x_high  = data[10:0];
            CSR_CLIP_Y_LOW:  regs.clip_y_low   = data[10:0];
            default:         regs.clip_y_high  = data[10:0];
         endcase
      endfunction

      // source color to rgb888, low bits of each channel repeat its high bits
      function bit [23:0] widen_color(bit [1:0] kind, bit [23:0] raw);
         int r, g, b;
         case (kind)
            KIND_332: begin
               r = raw[7:5];
               g = raw[4:2];
               r = (r << 5) | (r << 2) | (r >> 1);
               g = (g << 5) | (g << 2) | (g >> 1);
               b = raw[1:0] * 'h55;
            end
            KIND_565: begin
               r = raw[15:11];
               g = raw[10:5];
               b = raw[4:0];
               r = (r << 3) | (r >> 2);
               g = (g << 2) | (g >> 4);
               b = (b << 3) | (b >> 2);
            end
            default: return raw;
         endcase
         return {r[7:0], g[7:0], b[7:0]};
      endfunction

      // per channel weighted mix, full alpha passes the image color
      function bit [23:0] mix(bit [23:0] fg, bit [23:0] bg, bit [7:0] a);
         bit [23:0] res;
         int f, b, c;
         if (a == 8'd255) return fg;
         for (int k = 0; k < 3; k++) begin
            f = fg[8*k +: 8];
            b = bg[8*k +: 8];
            c = (f * a + b * (255 - a)) >> 8;
            res[8*k +: 8] = c[7:0];
         end
         return res;
      endfunction

      function int fit(int v, int top);
         if (v == 0) return 1;
         if (v > top) return top;
         return v;
      endfunction

      // advance the decoder by one pixel position and queue what it must produce
      function void note_pixel(req_beat_type beat);
         rsp_beat_type want;
         bit [23:0]    fg;
         bit           taken;
         bit           eol;
         int           w;
         int           h;
         w = fit(regs.image_width, IMAGE_MAX_W);
         h = fit(regs.image_height, IMAGE_MAX_H);
         if (regs.pixel_format >= FMT_RLE332 && regs.pixel_format <= FMT_RLE888) begin
            taken = (run_left == 0);
            if (taken) begin
               run_left  = (beat.record_count == 0) ? 9'd256 : {1'b0, beat.record_count};
               run_color = widen_color(2'(regs.pixel_format - FMT_RLE332),
                                       beat.record_color);
            end
            fg       = run_color;
            run_left = run_left - 1'b1;
         end else begin
            // raw codes line up with the layout kinds, unused codes read as 888
            taken = 1'b1;
            fg = widen_color((regs.pixel_format <= FMT_RAW888) ? regs.pixel_format[1:0]
                                                               : KIND_888,
                             beat.record_color);
         end
         want.pixel_visible = column >= regs.clip_x_low && column <= regs.clip_x_high &&
                              line >= regs.clip_y_low && line <= regs.clip_y_high;
         want.pixel_color   = want.pixel_visible ? mix(fg, beat.background_color, regs.alpha)
                                                 : beat.background_color;
         want.record_taken  = taken;
         eol                = column + 1 >= w;
         want.image_done    = eol && (line + 1 >= h);
         if (want.image_done) begin
            column   = '0;
            line     = '0;
            run_left = '0;
         end else if (eol) begin
            column = '0;
            line   = line + 1'b1;
         end else begin
            column = column + 1'b1;
         end
         expected_pixels.push_back(want);
      endfunction

      function void flag(string what, bit [23:0] want, bit [23:0] got);
         error_count++;
         if (reports < REPORT_CAP) begin
            reports++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
         end
      endfunction

      // compare one output pixel with the oldest prediction
      function void check_pixel(rsp_beat_type got);
         rsp_beat_type want;
         if (expected_pixels.size() == 0) begin
            error_count++;
            if (reports < REPORT_CAP) begin
               reports++;
               $display("%0t: pixel with none expected, expected none, actual %h",
                        $time, got);
            end
            return;
         end
         want = expected_pixels.pop_front();
         if (got.pixel_color !== want.pixel_color)
            flag("pixel_color", want.pixel_color, got.pixel_color);
         if (got.pixel_visible !== want.pixel_visible)
            flag("pixel_visible", want.pixel_visible, got.pixel_visible);
         if (got.record_taken !== want.record_taken)
            flag("record_taken", want.record_taken, got.record_taken);
         if (got.image_done !== want.image_done)
            flag("image_done", want.image_done, got.image_done);
      endfunction
   endclass

endpackage

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// top testbench that drives the pixmap decode and blend unit and checks every pixel
module tb;
   import rpdb_pkg::*;
   import pixmap_check_pkg::*;

   localparam int RANDOM_ITEMS    = 1250;
   localparam int CALM_ITEMS      = 200;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 20;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_beat_type          req_beat  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_beat_type          rsp_beat;
   logic                  csr_write = 1'b0;
   logic [2:0]            csr_index = CSR_FORMAT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bit              idle_on          = 1'b1;
   bit              hold_off_request = 1'b0;
   int              quiet_cycles     = 0;
   pixel_scoreboard sb;

   rle_pixmap_decode_blend_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // track register writes, accepted input beats and output beats
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write) sb.write_reg(csr_index, csr_wdata);
         if (req_valid && !req_stall) sb.note_pixel(req_beat);
         if (rsp_valid && !rsp_stall) sb.check_pixel(rsp_beat);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // receiver: random stall bursts plus one long hold-off on request
   initial begin : receiver
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_pixel(input logic [7:0] count, input logic [23:0] color,
                             input logic [23:0] bg);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_beat  <= '{record_count: count, record_color: color, background_color: bg};
      do @(posedge clock); while (req_stall);
   endtask

   // stop offering and wait for every predicted pixel to come out
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.expected_pixels.size() != 0);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic program_regs(input cfg_type c);
      write_reg(CSR_FORMAT, c.pixel_format);
      write_reg(CSR_ALPHA, c.alpha);
      write_reg(CSR_WIDTH, c.image_width);
      write_reg(CSR_HEIGHT, c.image_height);
      write_reg(CSR_CLIP_X_LOW, c.clip_x_low);
      write_reg(CSR_CLIP_X_HIGH, c.clip_x_high);
      write_reg(CSR_CLIP_Y_LOW, c.clip_y_low);
      write_reg(CSR_CLIP_Y_HIGH, c.clip_y_high);
      csr_write <= 1'b0;
   endtask

   function automatic cfg_type make_setup(logic [2:0] fmt, int a, int w, int h,
                                          int xl, int xh, int yl, int yh);
      cfg_type c;
      c.pixel_format = fmt;
      c.alpha        = a[7:0];
      c.image_width  = w[11:0];
      c.image_height = h[11:0];
      c.clip_x_low   = xl[10:0];
      c.clip_x_high  = xh[10:0];
      c.clip_y_low   = yl[10:0];
      c.clip_y_high  = yh[10:0];
      return c;
   endfunction

   // random settings, mostly small images with a few extreme sizes
   function automatic cfg_type pick_setup();
      cfg_type c;
      int      lo;
      c.pixel_format = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                   : 3'($urandom_range(0, 5));
      case ($urandom_range(0, 4))
         0:       c.alpha = 8'd0;
         1:       c.alpha = 8'd255;
         default: c.alpha = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 9))
         0:       c.image_width = 12'd0;
         1:       c.image_width = 12'hFFF;
         2:       c.image_width = 12'd2048;
         3:       c.image_width = 12'($urandom_range(0, 4095));
         default: c.image_width = 12'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 9))
         0:       c.image_height = 12'd0;
         1:       c.image_height = 12'hFFF;
         2:       c.image_height = 12'($urandom_range(0, 4095));
         default: c.image_height = 12'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 3))
         0: begin
            c.clip_x_low  = 11'd0;
            c.clip_x_high = 11'd2047;
            c.clip_y_low  = 11'd0;
            c.clip_y_high = 11'd2047;
         end
         1: begin
            c.clip_x_low  = 11'($urandom_range(0, 2047));
            c.clip_x_high = 11'($urandom_range(0, 2047));
            c.clip_y_low  = 11'($urandom_range(0, 2047));
            c.clip_y_high = 11'($urandom_range(0, 2047));
         end
         default: begin
            // small window near the origin, sometimes inverted
            lo            = $urandom_range(0, 12);
            c.clip_x_low  = 11'(lo);
            c.clip_x_high = 11'(lo + $urandom_range(0, 8) - 2);
            lo            = $urandom_range(0, 6);
            c.clip_y_low  = 11'(lo);
            c.clip_y_high = 11'(lo + $urandom_range(0, 5) - 1);
         end
      endcase
      return c;
   endfunction

   initial begin : main
      int          random_items;
      int          phase;
      int          n;
      bit          long_runs;
      logic [7:0]  count;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: run-length 332, one pixel image, counts at both ends
      send_pixel(8'd0, 24'hFFFFFF, 24'h000000);
      send_pixel(8'd255, 24'h000000, 24'hFFFFFF);
      send_pixel(8'd1, 24'hA5A5A5, 24'h5A5A5A);
      drain();

      // raw formats, zero alpha, zero and oversized dimensions
      program_regs(make_setup(FMT_RAW332, 0, 3, 1, 0, 2047, 0, 2047));
      send_pixel(8'd0, 24'hFFFFFF, 24'hFFFFFF);
      send_pixel(8'd255, 24'h000000, 24'h000000);
      send_pixel(8'd7, 24'h000055, 24'h123456);
      drain();
      program_regs(make_setup(FMT_RAW565, 128, 0, 0, 0, 2047, 0, 2047));
      send_pixel(8'd3, 24'h00FFFF, 24'h000000);
      send_pixel(8'd3, 24'hFF0000, 24'hFFFFFF);
      drain();
      program_regs(make_setup(FMT_RAW888, 1, 4095, 4095, 0, 2047, 0, 2047));
      send_pixel(8'd9, 24'hFFFFFF, 24'h000000);
      send_pixel(8'd9, 24'h000000, 24'hFFFFFF);
      drain();

      // unused format codes, narrow window, then an empty window
      program_regs(make_setup(3'd6, 254, 2, 2, 1, 1, 0, 0));
      repeat (4) send_pixel(8'd1, 24'h89ABCD, 24'h13579B);
      drain();
      program_regs(make_setup(3'd7, 255, 1, 3, 2047, 0, 2047, 0));
      send_pixel(8'd2, 24'h112233, 24'h445566);
      send_pixel(8'd2, 24'h778899, 24'hAABBCC);
      drain();

      // line past a shrunken height ends the image, runs restart each image
      program_regs(make_setup(FMT_RLE565, 200, 1, 1, 0, 2047, 0, 2047));
      send_pixel(8'd2, 24'h00F81F, 24'h0F0F0F);
      send_pixel(8'd0, 24'h0007E0, 24'hF0F0F0);
      send_pixel(8'd3, 24'h00FFFF, 24'h808080);
      drain();

      // a run spanning pixels, a clip window past the last column, then a shrunken width
      program_regs(make_setup(FMT_RLE888, 255, 8, 2, 2047, 2047, 0, 2047));
      send_pixel(8'd3, 24'hC0FFEE, 24'h101010);
      send_pixel(8'd7, 24'h000000, 24'h202020);
      send_pixel(8'd7, 24'h000000, 24'h303030);
      drain();
      program_regs(make_setup(FMT_RLE332, 64, 2, 2, 0, 0, 0, 2047));
      send_pixel(8'd0, 24'h0000E3, 24'h7F7F7F);
      send_pixel(8'd5, 24'h00001C, 24'h7F7F7F);
      drain();

      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         long_runs = 1'b0;
         n = $urandom_range(5, 60);
         idle_on = ($urandom_range(0, 3) != 0);
         if (phase == 0) begin
            // long runs that outlast an image line
            program_regs(make_setup(3'($urandom_range(3, 5)), $urandom_range(0, 255),
                                    32, 16, 0, 2047, 0, 2047));
            long_runs = 1'b1;
            n = 280;
         end else begin
            program_regs(pick_setup());
         end
         if (phase == 2) begin
            // stalled receiver while the sender keeps pushing
            idle_on = 1'b0;
            hold_off_request = 1'b1;
            n = 60;
         end
         if (random_items >= RANDOM_ITEMS - CALM_ITEMS) idle_on = 1'b0;
         for (int i = 0; i < n; i++) begin
            if (long_runs)
               count = ($urandom_range(0, 2) != 0) ? 8'd0 : 8'($urandom_range(0, 255));
            else
               count = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(1, 4));
            send_pixel(count, 24'($urandom), 24'($urandom));
         end
         random_items += n;
         phase++;
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
